// ===== hdl/rbst_pkg.sv =====
`default_nettype none
package rbst_pkg;

    // Default coordinate width, signed Q16.16.
    localparam int COORD_WIDTH_DEF = 32;

    // Configuration port geometry.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Register indexes of the box corners.
    localparam logic [REG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_Z = 3'd5;

    // Number of axes and of ordered axis pairs.
    localparam int NUM_AXES  = 3;
    localparam int NUM_PAIRS = 6;

endpackage
`default_nettype wire

// ===== hdl/rbst_slab.sv =====
`default_nettype none
module rbst_slab #(
    parameter int W = rbst_pkg::COORD_WIDTH_DEF
) (
    input  wire logic signed [W-1:0] i_orig,
    input  wire logic signed [W-1:0] i_dir,
    input  wire logic signed [W-1:0] i_bmin,
    input  wire logic signed [W-1:0] i_bmax,
    output logic                     o_bounded,
    output logic                     o_miss,
    output logic signed [W:0]        o_lo,
    output logic signed [W:0]        o_hi,
    output logic        [W-1:0]      o_den
);
    logic signed [W:0] n0;
    logic signed [W:0] n1;
    logic signed [W:0] m0;
    logic signed [W:0] m1;
    logic              neg;
    logic              zero;
    logic              in_slab;

    // Distances from the origin to both slab planes.
    assign n0 = {i_bmin[W-1], i_bmin} - {i_orig[W-1], i_orig};
    assign n1 = {i_bmax[W-1], i_bmax} - {i_orig[W-1], i_orig};

    // Fold the direction sign into the numerators so the denominator is positive.
    assign neg   = i_dir[W-1];
    assign m0    = neg ? -n0 : n0;
    assign m1    = neg ? -n1 : n1;
    assign o_den = neg ? -i_dir : i_dir;

    // Order entry and exit.
    assign o_lo = (m0 < m1) ? m0 : m1;
    assign o_hi = (m0 < m1) ? m1 : m0;

    // A parallel ray misses unless the origin lies within the slab.
    assign zero      = (i_dir == '0);
    assign in_slab   = !(i_orig < i_bmin) && !(i_orig > i_bmax);
    assign o_bounded = !zero;
    assign o_miss    = zero && !in_slab;
endmodule
`default_nettype wire

// ===== hdl/rbst_pair.sv =====
`default_nettype none
module rbst_pair #(
    parameter int W = rbst_pkg::COORD_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [W:0]  i_lo_a,
    input  wire logic        [W-1:0] i_den_a,
    input  wire logic signed [W:0]  i_hi_b,
    input  wire logic        [W-1:0] i_den_b,
    output logic                    o_le
);
    logic signed [2*W+1:0] r_p;
    logic signed [2*W+1:0] r_q;

    // Cross products, registered: lo_a / den_a <= hi_b / den_b.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_lo_a * $signed({1'b0, i_den_b});
            r_q <= i_hi_b * $signed({1'b0, i_den_a});
        end
    end

    assign o_le = (r_p <= r_q);
endmodule
`default_nettype wire

// ===== hdl/ray_box_slab_test_unit.sv =====
// Ray versus axis-aligned box test by the slab method.
// Input channel: i_valid / o_ready with the ray origin and direction, one
// item per ray. Output channel: o_valid / i_ready with o_hit, one item per
// ray, in order. The box corners sit in six APB registers (byte addresses
// 0x00..0x14: min x, y, z, then max x, y, z); the user must write them only
// while idle; the block does not enforce this. In order, one stage forms the
// slab numerators and denominators, one forms the twelve cross products, and
// the output register holds the compared and combined result. Throughput is
// one ray per cycle while the receiver does not stall; the twelve multipliers
// set that figure. When the receiver stalls with a result waiting, the whole
// pipeline holds and o_ready drops; nothing is lost or repeated. Empty slots
// still move, so o_ready stays high while the output register is empty.
// Reset clears all valid bits and the box registers to zero.
`default_nettype none
module ray_box_slab_test_unit #(
    parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [COORD_WIDTH-1:0]              i_origin_x,
    input  wire logic [COORD_WIDTH-1:0]              i_origin_y,
    input  wire logic [COORD_WIDTH-1:0]              i_origin_z,
    input  wire logic [COORD_WIDTH-1:0]              i_dir_x,
    input  wire logic [COORD_WIDTH-1:0]              i_dir_y,
    input  wire logic [COORD_WIDTH-1:0]              i_dir_z,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_hit,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rbst_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [rbst_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rbst_pkg::CFG_DATA_W-1:0]          prdata,
    output logic                                     pready
);
    import rbst_pkg::*;

    localparam int W = COORD_WIDTH;

    logic [CFG_DATA_W-1:0] r_box [2*NUM_AXES];
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  en;

    logic [W-1:0]        orig [NUM_AXES];
    logic [W-1:0]        dir  [NUM_AXES];
    logic [W-1:0]        bmin [NUM_AXES];
    logic [W-1:0]        bmax [NUM_AXES];
    logic [CFG_DATA_W+W-1:0] ext_min [NUM_AXES];
    logic [CFG_DATA_W+W-1:0] ext_max [NUM_AXES];

    logic                bnd  [NUM_AXES];
    logic                mis  [NUM_AXES];
    logic signed [W:0]   lo   [NUM_AXES];
    logic signed [W:0]   hi   [NUM_AXES];
    logic [W-1:0]        den  [NUM_AXES];

    logic                r_v1;
    logic                r_miss1;
    logic [NUM_AXES-1:0] r_bnd1;
    logic signed [W:0]   r_lo1  [NUM_AXES];
    logic signed [W:0]   r_hi1  [NUM_AXES];
    logic [W-1:0]        r_den1 [NUM_AXES];

    logic                r_v2;
    logic                r_miss2;
    logic [NUM_AXES-1:0] r_bnd2;
    logic [NUM_PAIRS-1:0] le;
    logic [NUM_PAIRS-1:0] need;

    logic r_v3;
    logic r_hit3;

    // Configuration registers.
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2*NUM_AXES; k++) begin
                r_box[k] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_MIN_X: r_box[0] <= pwdata;
                REG_MIN_Y: r_box[1] <= pwdata;
                REG_MIN_Z: r_box[2] <= pwdata;
                REG_MAX_X: r_box[3] <= pwdata;
                REG_MAX_Y: r_box[4] <= pwdata;
                REG_MAX_Z: r_box[5] <= pwdata;
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (reg_idx)
            REG_MIN_X: prdata = r_box[0];
            REG_MIN_Y: prdata = r_box[1];
            REG_MIN_Z: prdata = r_box[2];
            REG_MAX_X: prdata = r_box[3];
            REG_MAX_Y: prdata = r_box[4];
            REG_MAX_Z: prdata = r_box[5];
            default:   prdata = '0;
        endcase
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign en      = !r_v3 || i_ready;
    assign o_ready = en;

    assign orig[0] = i_origin_x;
    assign orig[1] = i_origin_y;
    assign orig[2] = i_origin_z;
    assign dir[0]  = i_dir_x;
    assign dir[1]  = i_dir_y;
    assign dir[2]  = i_dir_z;

    // Stage one: per-axis slab setup.
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        assign ext_min[a] = {{W{1'b0}}, r_box[a]};
        assign ext_max[a] = {{W{1'b0}}, r_box[a+NUM_AXES]};
        assign bmin[a]    = ext_min[a][W-1:0];
        assign bmax[a]    = ext_max[a][W-1:0];

        rbst_slab #(.W(W)) u_slab (
            .i_orig    (orig[a]),
            .i_dir     (dir[a]),
            .i_bmin    (bmin[a]),
            .i_bmax    (bmax[a]),
            .o_bounded (bnd[a]),
            .o_miss    (mis[a]),
            .o_lo      (lo[a]),
            .o_hi      (hi[a]),
            .o_den     (den[a])
        );

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_lo1[a]  <= lo[a];
                r_hi1[a]  <= hi[a];
                r_den1[a] <= den[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_miss1 <= mis[0] || mis[1] || mis[2];
            for (int a = 0; a < NUM_AXES; a++) begin
                r_bnd1[a] <= bnd[a];
            end
        end
    end

    // Stage two: cross products for every ordered pair of distinct axes.
    for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_pair
        localparam int PI = k / 2;
        localparam int PJ = (PI + 1 + (k % 2)) % NUM_AXES;

        rbst_pair #(.W(W)) u_pair (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_lo_a  (r_lo1[PI]),
            .i_den_a (r_den1[PI]),
            .i_hi_b  (r_hi1[PJ]),
            .i_den_b (r_den1[PJ]),
            .o_le    (le[k])
        );

        assign need[k] = r_bnd2[PI] && r_bnd2[PJ];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_miss2 <= r_miss1;
            r_bnd2  <= r_bnd1;
        end
    end

    // Stage three: combine the comparisons into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit3 <= !r_miss2 && ((le | ~need) == {NUM_PAIRS{1'b1}});
        end
    end

    assign o_valid = r_v3;
    assign o_hit   = r_hit3;
endmodule
`default_nettype wire

// ===== hdl/rbst_checker.sv =====
`default_nettype none
module rbst_checker #(
    parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_ready,
    input wire logic [COORD_WIDTH-1:0]          i_origin_x,
    input wire logic [COORD_WIDTH-1:0]          i_origin_y,
    input wire logic [COORD_WIDTH-1:0]          i_origin_z,
    input wire logic [COORD_WIDTH-1:0]          i_dir_x,
    input wire logic [COORD_WIDTH-1:0]          i_dir_y,
    input wire logic [COORD_WIDTH-1:0]          i_dir_z,
    input wire logic                            o_valid,
    input wire logic                            i_ready,
    input wire logic                            o_hit,
    input wire logic                            psel,
    input wire logic                            penable,
    input wire logic                            pwrite,
    input wire logic [rbst_pkg::CFG_ADDR_W-1:0] paddr,
    input wire logic [rbst_pkg::CFG_DATA_W-1:0] pwdata,
    input wire logic [rbst_pkg::CFG_DATA_W-1:0] prdata,
    input wire logic                            pready
);
    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit))
        else $error("stalled result changed");

    // The input side stalls only behind a waiting result.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    // An idle pipeline slot produces no result when it reaches the output register.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_valid || !o_ready) ##1 o_ready ##1 o_ready |=> (!o_valid || !$past(o_ready, 3)
        || $past(i_valid, 3)))
        else $error("result without an accepted item");
endmodule

bind ray_box_slab_test_unit rbst_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbst_checker (.*);
`default_nettype wire

// ===== test/ray_box_slab_test_unit_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module ray_box_slab_test_unit_test;
    import rbst_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [CW-1:0] ox;
        logic [CW-1:0] oy;
        logic [CW-1:0] oz;
        logic [CW-1:0] dx;
        logic [CW-1:0] dy;
        logic [CW-1:0] dz;
    } t_ray;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [CW-1:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic [CW-1:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_hit;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    ray_box_slab_test_unit u_top (.*);

    always #1 i_clk = ~i_clk;

    // Box corners as seen by the predictor: min x, y, z then max x, y, z.
    logic signed [CW-1:0] box_corner [6];
    t_ray ray_queue [$];
    bit hit_expected [$];
    int errors = 0;
    int cycle_count = 0;
    bit quiet_mode = 1'b0;
    bit hold_off_req = 1'b0;

    // Exact test a/b <= c/d for positive b and d.
    function automatic bit ratio_le(longint a, longint b, longint c, longint d);
        logic signed [127:0] lhs, rhs;
        lhs = 128'(signed'(a)) * 128'(signed'(d));
        rhs = 128'(signed'(c)) * 128'(signed'(b));
        return lhs <= rhs;
    endfunction

    // Slab method predictor for one ray against the configured box.
    function automatic bit predict_hit(t_ray r);
        logic [CW-1:0] org [3];
        logic [CW-1:0] dvec [3];
        longint entry [3], leave [3], den [3];
        bit bounded [3];
        longint o, d, mn, mx, n0, n1;
        org = '{r.ox, r.oy, r.oz};
        dvec = '{r.dx, r.dy, r.dz};
        for (int k = 0; k < 3; k++) begin
            o = longint'(signed'(org[k]));
            d = longint'(signed'(dvec[k]));
            mn = longint'(box_corner[k]);
            mx = longint'(box_corner[k + 3]);
            bounded[k] = 1'b0;
            entry[k] = 0;
            leave[k] = 0;
            den[k] = 1;
            if (d == 0) begin
                if (o < mn || o > mx) return 1'b0;
            end else begin
                n0 = mn - o;
                n1 = mx - o;
                if (d < 0) begin
                    n0 = -n0;
                    n1 = -n1;
                    d = -d;
                end
                bounded[k] = 1'b1;
                entry[k] = (n0 < n1) ? n0 : n1;
                leave[k] = (n0 < n1) ? n1 : n0;
                den[k] = d;
            end
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (bounded[i] && bounded[j] && i != j &&
                        !ratio_le(entry[i], den[i], leave[j], den[j]))
                    return 1'b0;
        return 1'b1;
    endfunction

    // Random coordinate: mostly moderate values, sometimes extremes or anything.
    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2, 3: return $urandom();
            default: return CW'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    function automatic logic [CW-1:0] rand_dir();
        if ($urandom_range(0, 5) == 0) return '0;
        if ($urandom_range(0, 5) == 0) return $urandom();
        return CW'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endfunction

    function automatic t_ray make_ray(logic [CW-1:0] ox, oy, oz, dx, dy, dz);
        t_ray r;
        r.ox = ox; r.oy = oy; r.oz = oz;
        r.dx = dx; r.dy = dy; r.dz = dz;
        return r;
    endfunction

    // Register write over the configuration port, done only while idle.
    task automatic write_corner(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx < 6) box_corner[idx] <= value;
    endtask

    task automatic load_box(logic [CW-1:0] c [6]);
        write_corner(REG_MIN_X, c[0]);
        write_corner(REG_MIN_Y, c[1]);
        write_corner(REG_MIN_Z, c[2]);
        write_corner(REG_MAX_X, c[3]);
        write_corner(REG_MAX_Y, c[4]);
        write_corner(REG_MAX_Z, c[5]);
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (ray_queue.size() != 0 || i_valid || hit_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver: offers queued rays, idling at random unless in a quiet stretch.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                hit_expected.push_back(predict_hit({i_origin_x, i_origin_y, i_origin_z,
                                                    i_dir_x, i_dir_y, i_dir_z}));
            end
            if (!i_valid || o_ready) begin
                if (ray_queue.size() != 0 && (quiet_mode || $urandom_range(0, 99) >= 29)) begin
                    t_ray r;
                    r = ray_queue.pop_front();
                    i_valid <= 1'b1;
                    i_origin_x <= r.ox; i_origin_y <= r.oy; i_origin_z <= r.oz;
                    i_dir_x <= r.dx; i_dir_y <= r.dy; i_dir_z <= r.dz;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each item against the oldest prediction and sets ready.
    int hold_count = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (hit_expected.size() == 0) begin
                    $error("hit: unexpected item, actual %0b", o_hit);
                    errors++;
                end else begin
                    bit e;
                    e = hit_expected.pop_front();
                    if (o_hit !== e) begin
                        $error("hit: expected %0b, actual %0b", e, o_hit);
                        errors++;
                    end
                end
            end
            if (hold_off_req && hold_count == 0) begin
                hold_count = 200;
                hold_off_req <= 1'b0;
            end
            if (hold_count > 0) begin
                hold_count--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= quiet_mode || $urandom_range(0, 99) >= 29;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [CW-1:0] box [6];
        logic [CW-1:0] maxv, minv;
        maxv = {1'b0, {(CW-1){1'b1}}};
        minv = {1'b1, {(CW-1){1'b0}}};
        for (int i = 0; i < 6; i++) box_corner[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Unit box from -1 to 1 on every axis.
        box = '{-(1 << 16), -(1 << 16), -(1 << 16), 1 << 16, 1 << 16, 1 << 16};
        load_box(box);
        ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 0));
        ray_queue.push_back(make_ray(2 << 16, 0, 0, 0, 0, 0));
        ray_queue.push_back(make_ray(1 << 16, 1 << 16, 1 << 16, 0, 0, 0));
        ray_queue.push_back(make_ray(-(5 << 16), 0, 0, 1 << 16, 0, 0));
        ray_queue.push_back(make_ray(-(5 << 16), 0, 0, -(1 << 16), 0, 0));
        ray_queue.push_back(make_ray(-(5 << 16), 1 << 16, 0, 1 << 16, 0, 0));
        ray_queue.push_back(make_ray(-(5 << 16), 2 << 16, 0, 1 << 16, 0, 0));
        // Grazing the edge diagonally: touching counts.
        ray_queue.push_back(make_ray(-(2 << 16), 0, 0, 1 << 16, 1 << 16, 0));
        ray_queue.push_back(make_ray(-(3 << 16), 0, 0, 1 << 16, 1 << 16, 0));
        ray_queue.push_back(make_ray(minv, minv, minv, maxv, maxv, maxv));
        ray_queue.push_back(make_ray(maxv, maxv, maxv, minv, minv, minv));
        ray_queue.push_back(make_ray(maxv, minv, 0, minv, maxv, 1));
        ray_queue.push_back(make_ray(0, 0, 0, 1, minv, maxv));
        wait_idle();

        // Inverted box on x, extreme box, then random boxes.
        box = '{1 << 16, -(1 << 16), -(1 << 16), -(1 << 16), 1 << 16, 1 << 16};
        load_box(box);
        ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 0));
        ray_queue.push_back(make_ray(-(4 << 16), 0, 0, 1 << 16, 0, 0));
        ray_queue.push_back(make_ray(0, 0, 0, 1 << 16, 1 << 16, 1 << 16));
        wait_idle();
        box = '{minv, minv, minv, maxv, maxv, maxv};
        load_box(box);
        ray_queue.push_back(make_ray(maxv, minv, maxv, 0, 0, 0));
        ray_queue.push_back(make_ray(maxv, minv, 0, 1, 1, minv));
        ray_queue.push_back(make_ray(minv, maxv, 0, maxv, 1, 0));
        wait_idle();

        for (int phase = 0; phase < 5; phase++) begin
            for (int k = 0; k < 3; k++) begin
                logic [CW-1:0] a, b;
                a = rand_coord();
                b = rand_coord();
                if ($urandom_range(0, 7) != 0 && $signed(a) > $signed(b)) begin
                    box[k] = b; box[k + 3] = a;
                end else begin
                    box[k] = a; box[k + 3] = b;
                end
            end
            load_box(box);
            if (phase == 1) hold_off_req <= 1'b1;
            quiet_mode = (phase == 2);
            for (int n = 0; n < 216; n++) begin
                t_ray r;
                r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
                r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
                // Give many rays the direction box centre minus half the origin, through min + max.
                if ($urandom_range(0, 1) == 0) begin
                    r.dx = CW'(($signed(box[0]) >>> 1) + ($signed(box[3]) >>> 1) -
                               ($signed(r.ox) >>> 1));
                    r.dy = CW'(($signed(box[1]) >>> 1) + ($signed(box[4]) >>> 1) -
                               ($signed(r.oy) >>> 1));
                    r.dz = CW'(($signed(box[2]) >>> 1) + ($signed(box[5]) >>> 1) -
                               ($signed(r.oz) >>> 1));
                end
                ray_queue.push_back(r);
            end
            wait_idle();
            quiet_mode = 1'b0;
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
